// ===== hw/rtl/uart_rx_fifo_register_model_top_macros.svh =====
// Assertion macros shared by the checker of the UART receive FIFO block.
// Each macro samples on the rising clock edge and is off while reset is high.
`ifndef UART_RX_FIFO_REGISTER_MODEL_TOP_MACROS_SVH
`define UART_RX_FIFO_REGISTER_MODEL_TOP_MACROS_SVH

// Same-cycle implication.
`define URFRM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define URFRM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/urfrm_pkg.sv =====
// Package for the UART receive FIFO block: payload types, command codes,
// register offsets and bit constants. No dependencies.
package urfrm_pkg;

   localparam int FIFO_DEPTH = 1024;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_RX    = 2'd2;

   localparam logic [2:0] OFS_DATA    = 3'd0;
   localparam logic [2:0] OFS_IER     = 3'd1;
   localparam logic [2:0] OFS_FCR_IIR = 3'd2;
   localparam logic [2:0] OFS_LSR     = 3'd5;

   localparam logic [7:0] LSR_READY     = 8'h01;
   localparam logic [7:0] LSR_THR_EMPTY = 8'h20;
   localparam logic [7:0] LSR_IDLE      = 8'h40;
   localparam logic [7:0] IIR_NONE      = 8'h01;
   localparam logic [7:0] IIR_RX_DATA   = 8'h04;
   localparam logic [7:0] RHR_EMPTY     = 8'hff;
   localparam int         IER_RX_ON_BIT = 0;
   localparam int         FCR_CLEAR_BIT = 1;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] reg_offset;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       irq_raise;
      logic       rx_dropped;
   } rsp_type;

endpackage

// ===== hw/rtl/uart_rx_fifo_register_model_top.sv =====
// Top level of the 16550-style UART subset: register file, receive ring FIFO
// and request/response pipeline. Depends on urfrm_pkg.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_ready   req_data (urfrm_pkg::req_type)
//   rsp_      out         rsp_valid / rsp_ready   rsp_data (urfrm_pkg::rsp_type)
//
// A request is registered on acceptance and processed once the response register is
// free or being taken, and its response is then registered; one request per cycle
// while the response side does not stall.
// The FIFO head byte is prefetched from the ring memory's single read port.
// Reset is synchronous; the ring memory is not cleared and needs no sweep.
// A stalled response holds the request stage, which then holds req_ready low.
module uart_rx_fifo_register_model_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  urfrm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output urfrm_pkg::rsp_type rsp_data
);
   import urfrm_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_ff;
   logic              s1_adv;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [7:0]        regs_ff [8];
   logic [7:0]        regs_in [8];
   logic [PTR_W-1:0]  rp_ff, rp_in, wp_ff, wp_in;
   logic              pend_ff, pend_in;

   logic [7:0]        rx_mem [FIFO_DEPTH];
   logic [7:0]        head_ff;
   logic              mem_we;

   logic              do_lsr, do_iir, do_irq;
   logic              empty_new, ier_new;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      s1_valid_in  = (req_valid && req_ready) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      regs_in = regs_ff;
      rp_in   = rp_ff;
      wp_in   = wp_ff;
      pend_in = pend_ff;
      mem_we  = 1'b0;
      rsp_in  = '0;
      do_lsr  = 1'b0;
      do_iir  = 1'b0;
      do_irq  = 1'b0;
      if (s1_adv) begin
         case (s1_ff.command)
            CMD_READ: begin
               case (s1_ff.reg_offset)
                  OFS_DATA: begin
                     if (rp_ff == wp_ff) begin
                        regs_in[OFS_DATA] = RHR_EMPTY;
                     end else begin
                        regs_in[OFS_DATA] = head_ff;
                        rp_in = ptr_next(rp_ff);
                     end
                     if (rp_in == wp_ff) begin
                        pend_in = 1'b0;
                     end
                     do_lsr = 1'b1;
                     do_iir = 1'b1;
                     do_irq = 1'b1;
                  end
                  OFS_IER, OFS_FCR_IIR: begin
                     do_iir = 1'b1;
                  end
                  OFS_LSR: begin
                     do_lsr = 1'b1;
                     do_iir = 1'b1;
                     do_irq = 1'b1;
                  end
                  default: ;
               endcase
            end
            CMD_WRITE: begin
               regs_in[s1_ff.reg_offset] = s1_ff.data_in;
               case (s1_ff.reg_offset)
                  OFS_DATA: begin
                     rsp_in.tx_valid = 1'b1;
                     rsp_in.tx_byte  = s1_ff.data_in;
                     do_lsr = 1'b1;
                  end
                  OFS_IER: begin
                     do_lsr = 1'b1;
                     do_iir = 1'b1;
                     do_irq = 1'b1;
                  end
                  OFS_FCR_IIR: begin
                     if (s1_ff.data_in[FCR_CLEAR_BIT]) begin
                        rp_in = '0;
                        wp_in = '0;
                     end
                     pend_in = 1'b0;
                     do_lsr  = 1'b1;
                     do_iir  = 1'b1;
                     do_irq  = 1'b1;
                  end
                  default: ;
               endcase
            end
            CMD_RX: begin
               if (ptr_next(wp_ff) == rp_ff) begin
                  rsp_in.rx_dropped = 1'b1;
               end else begin
                  mem_we = 1'b1;
                  wp_in  = ptr_next(wp_ff);
               end
               do_lsr = 1'b1;
               do_iir = 1'b1;
               do_irq = 1'b1;
            end
            default: ;
         endcase
      end

      // Status registers follow the FIFO level after this request's update.
      empty_new = (rp_in == wp_in);
      ier_new   = regs_in[OFS_IER][IER_RX_ON_BIT];
      if (do_lsr) begin
         regs_in[OFS_LSR] = LSR_THR_EMPTY | LSR_IDLE | (empty_new ? 8'h00 : LSR_READY);
      end
      if (do_iir) begin
         regs_in[OFS_FCR_IIR] = (ier_new && !empty_new) ? IIR_RX_DATA : IIR_NONE;
      end
      if (do_irq && !pend_in && ier_new && !empty_new) begin
         pend_in          = 1'b1;
         rsp_in.irq_raise = 1'b1;
      end
      if (s1_adv && s1_ff.command == CMD_READ) begin
         rsp_in.read_data = regs_in[s1_ff.reg_offset];
      end
   end

   // Ring memory; the head register tracks the entry at the next read pointer,
   // taking the write data when a push lands on that entry in the same cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rx_mem[wp_ff] <= s1_ff.data_in;
      end
      if (mem_we && wp_ff == rp_in) begin
         head_ff <= s1_ff.data_in;
      end else begin
         head_ff <= rx_mem[rp_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         pend_ff      <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= 8'h00;
         end
         regs_ff[OFS_LSR]     <= LSR_THR_EMPTY | LSR_IDLE;
         regs_ff[OFS_FCR_IIR] <= IIR_NONE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         pend_ff      <= pend_in;
         regs_ff      <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== hw/rtl/urfrm_checker.sv =====
// Port-level checker for the UART receive FIFO block, bound to its top level.
// Depends on urfrm_pkg and the shared assertion macro header.
`include "uart_rx_fifo_register_model_top_macros.svh"

module urfrm_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  urfrm_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  urfrm_pkg::rsp_type rsp_data
);
   import urfrm_pkg::*;

   logic    req_fire;

   assign req_fire = req_valid && req_ready;

   // A new response always comes from a request taken earlier through the request stage.
   `URFRM_ASSERT_IMP(a_rsp_from_req, $rose(rsp_valid), $past(req_fire, 2))

   // The response stays out, unchanged, while the consumer stalls it.
   `URFRM_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Nothing is presented in the cycle right after reset.
   `URFRM_ASSERT_IMP(a_rsp_after_reset, $past(reset), !rsp_valid)

   // With no response waiting, the request side is always open.
   `URFRM_ASSERT_IMP(a_req_flow, !rsp_valid, req_ready)

   // A waiting request keeps its valid and its payload.
   `URFRM_ASSERT_NXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req_data))

endmodule

bind uart_rx_fifo_register_model_top urfrm_checker u_urfrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_uart_rx_fifo_register_model_top.sv =====
// Self-checking testbench for the UART receive FIFO register block.
// Depends on urfrm_pkg and uart_rx_fifo_register_model_top; it predicts every
// response in its own model of the registers and the receive ring.
module tb_uart_rx_fifo_register_model_top;
   timeunit 1ns;
   timeprecision 1ps;

   import urfrm_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         DRAIN_LIMIT = 4000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Predicted UART state.
   logic [7:0] uart_regs [8];
   logic [7:0] rx_ring [FIFO_DEPTH];
   int         ring_rd;
   int         ring_wr;
   logic       irq_armed;

   rsp_type outcomes_due [$];
   int      error_count;
   int      cycle_count;
   int      sender_gap_pct;
   int      ready_stall_pct;
   int      hold_off_cycles;

   uart_rx_fifo_register_model_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_uart_rx_fifo_register_model_top: FAIL");
         $finish;
      end
   end

   function automatic logic ring_empty();
      return ring_rd == ring_wr;
   endfunction

   function automatic void refresh_lsr();
      uart_regs[OFS_LSR] = LSR_THR_EMPTY | LSR_IDLE | (ring_empty() ? 8'h00 : LSR_READY);
   endfunction

   function automatic void refresh_iir();
      if (uart_regs[OFS_IER][IER_RX_ON_BIT] && !ring_empty())
         uart_regs[OFS_FCR_IIR] = IIR_RX_DATA;
      else
         uart_regs[OFS_FCR_IIR] = IIR_NONE;
   endfunction

   // Recomputes both status registers and reports whether a new interrupt
   // episode starts.
   function automatic logic refresh_status();
      refresh_lsr();
      refresh_iir();
      if (!irq_armed && uart_regs[OFS_IER][IER_RX_ON_BIT] && !ring_empty()) begin
         irq_armed = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type uart_access_outcome(req_type r);
      rsp_type o;
      o = '0;
      case (r.command)
         CMD_READ: begin
            if (r.reg_offset == OFS_DATA) begin
               if (ring_empty()) begin
                  uart_regs[OFS_DATA] = RHR_EMPTY;
               end else begin
                  uart_regs[OFS_DATA] = rx_ring[ring_rd];
                  ring_rd = (ring_rd + 1) % FIFO_DEPTH;
               end
               if (ring_empty())
                  irq_armed = 1'b0;
               o.irq_raise = refresh_status();
            end else if (r.reg_offset == OFS_IER || r.reg_offset == OFS_FCR_IIR) begin
               refresh_iir();
            end else if (r.reg_offset == OFS_LSR) begin
               o.irq_raise = refresh_status();
            end
            o.read_data = uart_regs[r.reg_offset];
         end
         CMD_WRITE: begin
            uart_regs[r.reg_offset] = r.data_in;
            if (r.reg_offset == OFS_DATA) begin
               o.tx_valid = 1'b1;
               o.tx_byte  = r.data_in;
               refresh_lsr();
            end else if (r.reg_offset == OFS_IER) begin
               o.irq_raise = refresh_status();
            end else if (r.reg_offset == OFS_FCR_IIR) begin
               if (r.data_in[FCR_CLEAR_BIT]) begin
                  ring_rd = 0;
                  ring_wr = 0;
               end
               irq_armed   = 1'b0;
               o.irq_raise = refresh_status();
            end
         end
         CMD_RX: begin
            if ((ring_wr + 1) % FIFO_DEPTH == ring_rd) begin
               o.rx_dropped = 1'b1;
            end else begin
               rx_ring[ring_wr] = r.data_in;
               ring_wr = (ring_wr + 1) % FIFO_DEPTH;
            end
            o.irq_raise = refresh_status();
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Presents one request, with a random gap in front of it, and records the
   // predicted response once the block takes it.
   task automatic send_request(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (!req_ready);
      outcomes_due.push_back(uart_access_outcome(r));
   endtask

   task automatic send_fields(input logic [1:0] cmd, input logic [2:0] ofs,
                              input logic [7:0] data);
      req_type r;
      r.command    = cmd;
      r.reg_offset = ofs;
      r.data_in    = data;
      send_request(r);
   endtask

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   initial begin
      rsp_type want;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= ready_stall_pct);
         end
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch($sformatf("response %h with no request outstanding", rsp_data));
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  report_mismatch($sformatf("read_data got %h expected %h",
                                            rsp_data.read_data, want.read_data));
               if (rsp_data.tx_valid !== want.tx_valid)
                  report_mismatch($sformatf("tx_valid got %b expected %b",
                                            rsp_data.tx_valid, want.tx_valid));
               if (rsp_data.tx_byte !== want.tx_byte)
                  report_mismatch($sformatf("tx_byte got %h expected %h",
                                            rsp_data.tx_byte, want.tx_byte));
               if (rsp_data.irq_raise !== want.irq_raise)
                  report_mismatch($sformatf("irq_raise got %b expected %b",
                                            rsp_data.irq_raise, want.irq_raise));
               if (rsp_data.rx_dropped !== want.rx_dropped)
                  report_mismatch($sformatf("rx_dropped got %b expected %b",
                                            rsp_data.rx_dropped, want.rx_dropped));
            end
         end
      end
   end

   task automatic test_register_basics();
      for (int i = 0; i < 8; i++)
         send_fields(CMD_READ, i[2:0], 8'h00);
      send_fields(CMD_UNUSED, 3'd7, 8'hff);
      send_fields(CMD_WRITE, OFS_DATA, 8'h00);
      send_fields(CMD_WRITE, OFS_DATA, 8'hff);
      send_fields(CMD_WRITE, OFS_LSR, 8'ha5);
      send_fields(CMD_WRITE, 3'd7, 8'hff);
      send_fields(CMD_READ, 3'd7, 8'h00);
   endtask

   task automatic test_receive_interrupt();
      send_fields(CMD_WRITE, OFS_IER, 8'h01);
      send_fields(CMD_RX, 3'd0, 8'h5a);
      send_fields(CMD_RX, 3'd7, 8'ha5);
      send_fields(CMD_READ, OFS_FCR_IIR, 8'h00);
      send_fields(CMD_READ, OFS_LSR, 8'h00);
      // The third read finds the ring empty and returns the empty marker.
      repeat (3)
         send_fields(CMD_READ, OFS_DATA, 8'h00);
      send_fields(CMD_WRITE, OFS_FCR_IIR, 8'h00);
      send_fields(CMD_WRITE, OFS_IER, 8'h00);
   endtask

   // Fills the ring to capacity behind a long receiver hold-off, overflows it,
   // and wraps the write pointer before clearing everything.
   task automatic test_fifo_overflow();
      send_fields(CMD_WRITE, OFS_FCR_IIR, 8'h02);
      send_fields(CMD_WRITE, OFS_IER, 8'h01);
      hold_off_cycles = 600;
      repeat (FIFO_DEPTH + 2)
         send_fields(CMD_RX, 3'($urandom_range(7)), 8'($urandom_range(255)));
      send_fields(CMD_READ, OFS_LSR, 8'h00);
      repeat (10)
         send_fields(CMD_READ, OFS_DATA, 8'h00);
      repeat (11)
         send_fields(CMD_RX, 3'($urandom_range(7)), 8'($urandom_range(255)));
      send_fields(CMD_READ, OFS_FCR_IIR, 8'h00);
      send_fields(CMD_WRITE, OFS_FCR_IIR, 8'hff);
      send_fields(CMD_READ, OFS_DATA, 8'h00);
      send_fields(CMD_READ, OFS_LSR, 8'h00);
   endtask

   task automatic test_random_traffic(input int count, input int gap_pct, input int stall);
      req_type r;
      int      pick;
      sender_gap_pct  = gap_pct;
      ready_stall_pct = stall;
      repeat (count) begin
         pick         = $urandom_range(99);
         r.data_in    = 8'($urandom_range(255));
         r.reg_offset = 3'($urandom_range(7));
         if (pick < 40) begin
            r.command = CMD_RX;
         end else if (pick < 75) begin
            r.command = CMD_READ;
            case ($urandom_range(3))
               0: r.reg_offset = OFS_DATA;
               1: r.reg_offset = OFS_LSR;
               2: r.reg_offset = OFS_FCR_IIR;
               default: ;
            endcase
         end else if (pick < 95) begin
            r.command = CMD_WRITE;
            if ($urandom_range(1))
               r.reg_offset = $urandom_range(1) ? OFS_IER : OFS_FCR_IIR;
            // Clearing the ring is kept occasional so that it builds some depth.
            if (r.reg_offset == OFS_FCR_IIR && $urandom_range(3) != 0)
               r.data_in[FCR_CLEAR_BIT] = 1'b0;
         end else begin
            r.command = CMD_UNUSED;
         end
         send_request(r);
      end
   endtask

   initial begin
      int drain;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      rsp_ready       = 1'b0;
      error_count     = 0;
      cycle_count     = 0;
      sender_gap_pct  = 0;
      ready_stall_pct = 0;
      hold_off_cycles = 0;
      uart_regs       = '{default: 8'h00};
      uart_regs[OFS_LSR]     = LSR_THR_EMPTY | LSR_IDLE;
      uart_regs[OFS_FCR_IIR] = IIR_NONE;
      ring_rd   = 0;
      ring_wr   = 0;
      irq_armed = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_basics();
      test_receive_interrupt();
      test_fifo_overflow();
      test_random_traffic(230, 0, 0);
      test_random_traffic(230, 55, 0);
      test_random_traffic(230, 0, 55);
      test_random_traffic(230, 30, 30);

      @(negedge clock);
      req_valid <= 1'b0;
      drain = 0;
      while (outcomes_due.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (outcomes_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", outcomes_due.size()));

      if (error_count == 0) begin
         $display("tb_uart_rx_fifo_register_model_top: PASS");
      end else begin
         $display("tb_uart_rx_fifo_register_model_top: FAIL");
      end
      $finish;
   end

endmodule
